/* hdl/vea_pkg.sv */
// Shared constants and sideband types for the endpoint-along-direction pipeline.
// Used by vea_sqrt, vea_div, vea_checker and the top level; depends on nothing.
package vea_pkg;

    localparam int COORD_W = 32;               // Q16.16 coordinate
    localparam int AXES    = 3;
    localparam int MAG_W   = 32;               // |target - origin| per axis, |travel|
    localparam int SQ_W    = 2 * MAG_W;        // one squared component
    localparam int SUM_W   = SQ_W + 2;         // sum of three squares
    localparam int ROOT_W  = SUM_W / 2;        // floor square root
    localparam int PROD_W  = 2 * MAG_W;        // |d| * |travel|
    localparam int QUO_W   = PROD_W;           // rounded quotient
    localparam int WIDE_W  = QUO_W + 2;        // signed endpoint before clipping

    localparam int IN_FIELDS = 7;
    localparam int S_DATA_W  = IN_FIELDS * COORD_W;
    localparam int M_DATA_W  = AXES * COORD_W;
    localparam int M_USER_W  = 2;

    localparam int USER_ZERO = 0;              // tuser bit: zero-length direction
    localparam int USER_SAT  = 1;              // tuser bit: some coordinate clipped

    localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

    typedef struct packed {
        logic [AXES-1:0][PROD_W-1:0]  prod;
        logic [AXES-1:0][COORD_W-1:0] org;
        logic [AXES-1:0]              neg;
        logic                         zero;
    } sqrt_side_t;

    typedef struct packed {
        logic [AXES-1:0][COORD_W-1:0] org;
        logic [AXES-1:0]              neg;
        logic                         zero;
    } div_side_t;

endpackage

/* hdl/vea_sqrt.sv */
// Pipelined floor square root, one result bit per register stage.
// Uses vea_pkg widths; sideband data rides along with each item.
module vea_sqrt #(
    parameter int SIDE_W = 1
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [vea_pkg::SUM_W-1:0]  in_rad,
    input  logic [SIDE_W-1:0]          in_side,
    output logic                       out_valid,
    output logic [vea_pkg::ROOT_W-1:0] out_root,
    output logic [SIDE_W-1:0]          out_side
);

    localparam int STEPS = vea_pkg::ROOT_W;
    localparam int REM_W = vea_pkg::ROOT_W + 2;
    localparam int RAD_W = vea_pkg::SUM_W;

    logic              valid_in [0:STEPS];
    logic [RAD_W-1:0]  rad_in   [0:STEPS];
    logic [REM_W-1:0]  rem_in   [0:STEPS];
    logic [STEPS-1:0]  root_in  [0:STEPS];
    logic [SIDE_W-1:0] side_in  [0:STEPS];

    logic              valid_reg [0:STEPS-1];
    logic [RAD_W-1:0]  rad_reg   [0:STEPS-1];
    logic [REM_W-1:0]  rem_reg   [0:STEPS-1];
    logic [STEPS-1:0]  root_reg  [0:STEPS-1];
    logic [SIDE_W-1:0] side_reg  [0:STEPS-1];

    assign valid_in[0] = in_valid;
    assign rad_in[0]   = in_rad;
    assign rem_in[0]   = '0;
    assign root_in[0]  = '0;
    assign side_in[0]  = in_side;

    genvar j;
    generate
        for (j = 0; j < STEPS; j++) begin : g_step
            logic [REM_W+1:0] rem_try;
            logic [REM_W+1:0] trial;
            logic [REM_W+1:0] rem_diff;
            logic             ge;

            assign rem_try  = {rem_in[j], rad_in[j][RAD_W-1 -: 2]};
            assign trial    = {2'b00, root_in[j], 2'b01};
            assign ge       = rem_try >= trial;
            assign rem_diff = rem_try - trial;

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[j] <= 1'b0;
                end else if (en) begin
                    valid_reg[j] <= valid_in[j];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[j]  <= {rad_in[j][RAD_W-3:0], 2'b00};
                    rem_reg[j]  <= ge ? rem_diff[REM_W-1:0] : rem_try[REM_W-1:0];
                    root_reg[j] <= {root_in[j][STEPS-2:0], ge};
                    side_reg[j] <= side_in[j];
                end
            end

            assign valid_in[j+1] = valid_reg[j];
            assign rad_in[j+1]   = rad_reg[j];
            assign rem_in[j+1]   = rem_reg[j];
            assign root_in[j+1]  = root_reg[j];
            assign side_in[j+1]  = side_reg[j];
        end
    endgenerate

    assign out_valid = valid_in[STEPS];
    assign out_root  = root_in[STEPS];
    assign out_side  = side_in[STEPS];

endmodule

/* hdl/vea_div.sv */
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Uses vea_pkg widths; sideband data rides along with each item.
module vea_div #(
    parameter int SIDE_W = 1
) (
    input  logic                                           aclk,
    input  logic                                           aresetn,
    input  logic                                           en,
    input  logic                                           in_valid,
    input  logic [vea_pkg::AXES-1:0][vea_pkg::QUO_W-1:0]   in_num,
    input  logic [vea_pkg::ROOT_W-1:0]                     in_den,
    input  logic [SIDE_W-1:0]                              in_side,
    output logic                                           out_valid,
    output logic [vea_pkg::AXES-1:0][vea_pkg::QUO_W-1:0]   out_quo,
    output logic [SIDE_W-1:0]                              out_side
);

    localparam int STEPS = vea_pkg::QUO_W;
    localparam int DEN_W = vea_pkg::ROOT_W;
    localparam int LANES = vea_pkg::AXES;

    typedef logic [LANES-1:0][STEPS-1:0] word_t;
    typedef logic [LANES-1:0][DEN_W-1:0] rem_t;

    logic              valid_in [0:STEPS];
    word_t             num_in   [0:STEPS];
    word_t             quo_in   [0:STEPS];
    rem_t              rem_in   [0:STEPS];
    logic [DEN_W-1:0]  den_in   [0:STEPS];
    logic [SIDE_W-1:0] side_in  [0:STEPS];

    logic              valid_reg [0:STEPS-1];
    word_t             num_reg   [0:STEPS-1];
    word_t             quo_reg   [0:STEPS-1];
    rem_t              rem_reg   [0:STEPS-1];
    logic [DEN_W-1:0]  den_reg   [0:STEPS-1];
    logic [SIDE_W-1:0] side_reg  [0:STEPS-1];

    assign valid_in[0] = in_valid;
    assign num_in[0]   = in_num;
    assign quo_in[0]   = '0;
    assign rem_in[0]   = '0;
    assign den_in[0]   = in_den;
    assign side_in[0]  = in_side;

    genvar j, k;
    generate
        for (j = 0; j < STEPS; j++) begin : g_step
            word_t num_next;
            word_t quo_next;
            rem_t  rem_next;

            for (k = 0; k < LANES; k++) begin : g_lane
                logic [DEN_W:0] rem_try;
                logic [DEN_W:0] rem_diff;
                logic           ge;

                assign rem_try     = {rem_in[j][k], num_in[j][k][STEPS-1]};
                assign ge          = rem_try >= {1'b0, den_in[j]};
                assign rem_diff    = rem_try - {1'b0, den_in[j]};
                assign rem_next[k] = ge ? rem_diff[DEN_W-1:0] : rem_try[DEN_W-1:0];
                assign quo_next[k] = {quo_in[j][k][STEPS-2:0], ge};
                assign num_next[k] = {num_in[j][k][STEPS-2:0], 1'b0};
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    valid_reg[j] <= 1'b0;
                end else if (en) begin
                    valid_reg[j] <= valid_in[j];
                end
            end

            always_ff @(posedge aclk) begin
                if (en) begin
                    num_reg[j]  <= num_next;
                    quo_reg[j]  <= quo_next;
                    rem_reg[j]  <= rem_next;
                    den_reg[j]  <= den_in[j];
                    side_reg[j] <= side_in[j];
                end
            end

            assign valid_in[j+1] = valid_reg[j];
            assign num_in[j+1]   = num_reg[j];
            assign quo_in[j+1]   = quo_reg[j];
            assign rem_in[j+1]   = rem_reg[j];
            assign den_in[j+1]   = den_reg[j];
            assign side_in[j+1]  = side_reg[j];
        end
    endgenerate

    assign out_valid = valid_in[STEPS];
    assign out_quo   = quo_in[STEPS];
    assign out_side  = side_in[STEPS];

endmodule

/* hdl/vector_endpoint_along_direction_unit.sv */
// Endpoint along a direction in 3D, signed Q16.16 coordinates.
// Top level; uses vea_pkg, vea_sqrt and vea_div.
//
// Usage:
//   Slave channel s_*: one transfer carries origin, target and travel distance.
//   Master channel m_*: one transfer per input with the endpoint
//   origin + (target - origin) * travel / |target - origin|, each coordinate
//   saturated, plus tuser flags zero_length and saturated.
//   A zero-length direction returns the origin with zero_length set.
// Stages: three front stages (difference, multipliers, sum of squares), 33
//   square-root stages (one root bit each), one rounding-offset stage, 64
//   divider stages (one quotient bit each) and the output register, from an
//   accepted input to m_tvalid.
// Throughput: one transfer per cycle unless stalled; a new item in each stage.
// Stall: the whole pipeline, output register included, holds while m_tvalid is
//   high and m_tready is low; s_tready is low exactly then, so nothing is lost
//   or repeated. s_tready is combinational from m_tready.
// Reset: aresetn low clears all stage valid bits and m_tvalid; items in flight
//   are dropped.
module vector_endpoint_along_direction_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // origin_x, origin_y, origin_z, target_x, target_y, target_z, travel
    input  logic [vea_pkg::S_DATA_W-1:0]   s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // end_x, end_y, end_z
    output logic [vea_pkg::M_DATA_W-1:0]   m_tdata,
    // zero_length, saturated
    output logic [vea_pkg::M_USER_W-1:0]   m_tuser
);

    localparam int AXES    = vea_pkg::AXES;
    localparam int COORD_W = vea_pkg::COORD_W;
    localparam int MAG_W   = vea_pkg::MAG_W;
    localparam int SQ_W    = vea_pkg::SQ_W;
    localparam int SUM_W   = vea_pkg::SUM_W;
    localparam int ROOT_W  = vea_pkg::ROOT_W;
    localparam int PROD_W  = vea_pkg::PROD_W;
    localparam int QUO_W   = vea_pkg::QUO_W;
    localparam int WIDE_W  = vea_pkg::WIDE_W;

    logic en;
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // ---- stage 1: differences and magnitudes
    logic [AXES-1:0][COORD_W-1:0] org_in;
    logic [AXES-1:0][COORD_W-1:0] tgt_in;
    logic [COORD_W-1:0]           trav_in;
    logic [AXES-1:0][MAG_W-1:0]   dmag_next;
    logic [AXES-1:0]              dneg_next;
    logic [MAG_W-1:0]             tmag_next;

    logic                         v1_reg;
    logic [AXES-1:0][COORD_W-1:0] org1_reg;
    logic [AXES-1:0][MAG_W-1:0]   dmag1_reg;
    logic [AXES-1:0]              dneg1_reg;
    logic [MAG_W-1:0]             tmag1_reg;
    logic                         tneg1_reg;

    assign trav_in   = s_tdata[6*COORD_W +: COORD_W];
    assign tmag_next = trav_in[COORD_W-1] ? (~trav_in + 1'b1) : trav_in;

    genvar a;
    generate
        for (a = 0; a < AXES; a++) begin : g_diff
            logic [COORD_W:0] diff;
            logic [COORD_W:0] dabs;
            assign org_in[a]    = s_tdata[a*COORD_W +: COORD_W];
            assign tgt_in[a]    = s_tdata[(a+AXES)*COORD_W +: COORD_W];
            assign diff         = {tgt_in[a][COORD_W-1], tgt_in[a]}
                                - {org_in[a][COORD_W-1], org_in[a]};
            assign dabs         = diff[COORD_W] ? (~diff + 1'b1) : diff;
            assign dmag_next[a] = dabs[MAG_W-1:0];
            assign dneg_next[a] = diff[COORD_W];
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            org1_reg  <= org_in;
            dmag1_reg <= dmag_next;
            dneg1_reg <= dneg_next;
            tmag1_reg <= tmag_next;
            tneg1_reg <= trav_in[COORD_W-1];
        end
    end

    // ---- stage 2: squares and |d| * |travel|
    logic [AXES-1:0][SQ_W-1:0]    sq_next;
    logic [AXES-1:0][PROD_W-1:0]  prod_next;

    logic                         v2_reg;
    logic [AXES-1:0][COORD_W-1:0] org2_reg;
    logic [AXES-1:0][SQ_W-1:0]    sq2_reg;
    logic [AXES-1:0][PROD_W-1:0]  prod2_reg;
    logic [AXES-1:0]              neg2_reg;

    generate
        for (a = 0; a < AXES; a++) begin : g_mul
            assign sq_next[a]   = dmag1_reg[a] * dmag1_reg[a];
            assign prod_next[a] = dmag1_reg[a] * tmag1_reg;
        end
    endgenerate

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (en) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            org2_reg  <= org1_reg;
            sq2_reg   <= sq_next;
            prod2_reg <= prod_next;
            neg2_reg  <= dneg1_reg ^ {AXES{tneg1_reg}};
        end
    end

    // ---- stage 3: sum of squares
    logic [SUM_W-1:0]    sum_next;
    logic                v3_reg;
    logic [SUM_W-1:0]    sum3_reg;
    vea_pkg::sqrt_side_t side3_reg;

    assign sum_next = SUM_W'(sq2_reg[0]) + SUM_W'(sq2_reg[1]) + SUM_W'(sq2_reg[2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (en) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sum3_reg       <= sum_next;
            side3_reg.prod <= prod2_reg;
            side3_reg.org  <= org2_reg;
            side3_reg.neg  <= neg2_reg;
            side3_reg.zero <= (sum_next == '0);
        end
    end

    // ---- square root
    logic                sq_valid;
    logic [ROOT_W-1:0]   len;
    vea_pkg::sqrt_side_t sq_side;

    vea_sqrt #(
        .SIDE_W ($bits(vea_pkg::sqrt_side_t))
    ) u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v3_reg),
        .in_rad    (sum3_reg),
        .in_side   (side3_reg),
        .out_valid (sq_valid),
        .out_root  (len),
        .out_side  (sq_side)
    );

    // ---- rounding offset: n + floor(L / 2)
    logic                          v4_reg;
    logic [AXES-1:0][QUO_W-1:0]    num4_reg;
    logic [ROOT_W-1:0]             len4_reg;
    vea_pkg::div_side_t            side4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v4_reg <= 1'b0;
        end else if (en) begin
            v4_reg <= sq_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < AXES; i++) begin
                num4_reg[i] <= sq_side.prod[i] + QUO_W'(len >> 1);
            end
            len4_reg       <= len;
            side4_reg.org  <= sq_side.org;
            side4_reg.neg  <= sq_side.neg;
            side4_reg.zero <= sq_side.zero;
        end
    end

    // ---- divide by length
    logic                       dv_valid;
    logic [AXES-1:0][QUO_W-1:0] quo;
    vea_pkg::div_side_t         dv_side;

    vea_div #(
        .SIDE_W ($bits(vea_pkg::div_side_t))
    ) u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v4_reg),
        .in_num    (num4_reg),
        .in_den    (len4_reg),
        .in_side   (side4_reg),
        .out_valid (dv_valid),
        .out_quo   (quo),
        .out_side  (dv_side)
    );

    // ---- endpoint, clipping, output register
    logic [AXES-1:0][COORD_W-1:0] end_next;
    logic [AXES-1:0]              clip;

    generate
        for (a = 0; a < AXES; a++) begin : g_end
            logic signed [WIDE_W-1:0] qw;
            logic signed [WIDE_W-1:0] off;
            logic signed [WIDE_W-1:0] ew;
            logic                     hi;
            logic                     lo;

            assign qw  = {2'b00, quo[a]};
            assign off = dv_side.neg[a] ? -qw : qw;
            assign ew  = {{(WIDE_W-COORD_W){dv_side.org[a][COORD_W-1]}}, dv_side.org[a]} + off;
            assign hi  = ew > WIDE_W'(vea_pkg::COORD_MAX);
            assign lo  = ew < WIDE_W'(vea_pkg::COORD_MIN);

            always_comb begin
                if (dv_side.zero) begin
                    end_next[a] = dv_side.org[a];
                    clip[a]     = 1'b0;
                end else if (hi) begin
                    end_next[a] = vea_pkg::COORD_MAX;
                    clip[a]     = 1'b1;
                end else if (lo) begin
                    end_next[a] = vea_pkg::COORD_MIN;
                    clip[a]     = 1'b1;
                end else begin
                    end_next[a] = ew[COORD_W-1:0];
                    clip[a]     = 1'b0;
                end
            end
        end
    endgenerate

    logic                           m_tvalid_reg;
    logic [vea_pkg::M_DATA_W-1:0]   m_tdata_reg;
    logic [vea_pkg::M_USER_W-1:0]   m_tuser_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (en) begin
            m_tvalid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_tdata_reg                     <= end_next;
            m_tuser_reg[vea_pkg::USER_ZERO] <= dv_side.zero;
            m_tuser_reg[vea_pkg::USER_SAT]  <= |clip;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

/* hdl/vea_checker.sv */
// Port-level checks for vector_endpoint_along_direction_unit, attached by bind.
// Uses vea_pkg field positions.
module vea_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [vea_pkg::M_DATA_W-1:0] m_tdata,
    input logic [vea_pkg::M_USER_W-1:0] m_tuser
);

    localparam int CW = vea_pkg::COORD_W;

    // a result held by the receiver stays put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // input side is open exactly when the output register can move
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("s_tready does not follow output stall");

    // zero-length direction never reports clipping
    a_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[vea_pkg::USER_ZERO] |-> !m_tuser[vea_pkg::USER_SAT])
        else $error("zero_length with saturated");

    // saturated means some coordinate sits at a range limit
    a_clip: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[vea_pkg::USER_SAT] |->
            m_tdata[0*CW +: CW] == vea_pkg::COORD_MAX ||
            m_tdata[0*CW +: CW] == vea_pkg::COORD_MIN ||
            m_tdata[1*CW +: CW] == vea_pkg::COORD_MAX ||
            m_tdata[1*CW +: CW] == vea_pkg::COORD_MIN ||
            m_tdata[2*CW +: CW] == vea_pkg::COORD_MAX ||
            m_tdata[2*CW +: CW] == vea_pkg::COORD_MIN)
        else $error("saturated flag without a clipped coordinate");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid after reset");

endmodule

bind vector_endpoint_along_direction_unit vea_checker u_vea_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
